[src/kufef_pkg.sv]
// Package: widths, control word and microprogram of the Kruskal union-find edge filter.
`default_nettype none

package kufef_pkg;

  localparam int NODE_COUNT   = 1024;
  localparam int NODE_W       = $clog2(NODE_COUNT);
  localparam int NODE_FIELD_W = 10;
  localparam int WEIGHT_W     = 32;
  localparam int TOTAL_W      = 48;
  localparam int UPC_W        = 4;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [UPC_W-1:0]  upc_t;

  typedef enum logic [UPC_W-1:0] {
    ST_CLEAR,
    ST_WAIT,
    ST_START,
    ST_RD_A,
    ST_WALK_A,
    ST_CHK_A,
    ST_CMP_A,
    ST_SWAP,
    ST_RD_B,
    ST_WALK_B,
    ST_CHK_B,
    ST_CMP_B,
    ST_LINK_CHK,
    ST_LINK,
    ST_RESULT
  } step_t;

  typedef enum logic [3:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_IN_FIRE,
    CND_OUT_FREE,
    CND_CLR_DONE,
    CND_OUT_RANGE,
    CND_PAR_NE,
    CND_CUR_IS_ROOT,
    CND_ROOTS_EQ
  } cond_sel_t;

  typedef enum logic [1:0] {
    RD_ROOT,
    RD_RDATA,
    RD_CUR
  } rd_sel_t;

  typedef enum logic [1:0] {
    WA_CUR,
    WA_RA,
    WA_CNT
  } wa_sel_t;

  typedef enum logic [1:0] {
    LD_HOLD,
    LD_NODE_A,
    LD_NODE_B,
    LD_RDATA
  } ld_sel_t;

  typedef struct packed {
    logic      in_ready;
    logic      we;
    wa_sel_t   wa;
    rd_sel_t   rd;
    ld_sel_t   cur_ld;
    ld_sel_t   root_ld;
    logic      ra_ld;
    logic      clr_acc;
    logic      accum;
    logic      load_out;
    logic      clr_inc;
    logic      wait_c;
    cond_sel_t cond;
    step_t     target;
  } ctl_t;

  typedef struct packed {
    logic in_fire;
    logic out_free;
    logic clr_done;
    logic out_range;
    logic par_ne;
    logic cur_is_root;
    logic roots_eq;
  } flags_t;

  // Microprogram. A taken condition jumps to target; otherwise the step
  // either holds (wait_c) or falls through to the next one.
  function automatic ctl_t ucode(input upc_t pc);
    ctl_t c;
    c = '0;
    unique case (pc)
      ST_CLEAR: begin
        c.we      = 1'b1;
        c.wa      = WA_CNT;
        c.clr_inc = 1'b1;
        c.wait_c  = 1'b1;
        c.cond    = CND_CLR_DONE;
        c.target  = ST_WAIT;
      end
      ST_WAIT: begin
        c.in_ready = 1'b1;
        c.wait_c   = 1'b1;
        c.cond     = CND_IN_FIRE;
        c.target   = ST_START;
      end
      ST_START: begin
        c.cur_ld  = LD_NODE_A;
        c.root_ld = LD_NODE_A;
        c.clr_acc = 1'b1;
        c.cond    = CND_OUT_RANGE;
        c.target  = ST_RESULT;
      end
      ST_RD_A: begin
        c.rd = RD_ROOT;
      end
      ST_WALK_A: begin
        c.rd      = RD_RDATA;
        c.root_ld = LD_RDATA;
        c.cond    = CND_PAR_NE;
        c.target  = ST_WALK_A;
      end
      ST_CHK_A: begin
        c.rd     = RD_CUR;
        c.cond   = CND_CUR_IS_ROOT;
        c.target = ST_SWAP;
      end
      ST_CMP_A: begin
        c.we     = 1'b1;
        c.wa     = WA_CUR;
        c.cur_ld = LD_RDATA;
        c.cond   = CND_ALWAYS;
        c.target = ST_CHK_A;
      end
      ST_SWAP: begin
        c.ra_ld   = 1'b1;
        c.cur_ld  = LD_NODE_B;
        c.root_ld = LD_NODE_B;
      end
      ST_RD_B: begin
        c.rd = RD_ROOT;
      end
      ST_WALK_B: begin
        c.rd      = RD_RDATA;
        c.root_ld = LD_RDATA;
        c.cond    = CND_PAR_NE;
        c.target  = ST_WALK_B;
      end
      ST_CHK_B: begin
        c.rd     = RD_CUR;
        c.cond   = CND_CUR_IS_ROOT;
        c.target = ST_LINK_CHK;
      end
      ST_CMP_B: begin
        c.we     = 1'b1;
        c.wa     = WA_CUR;
        c.cur_ld = LD_RDATA;
        c.cond   = CND_ALWAYS;
        c.target = ST_CHK_B;
      end
      ST_LINK_CHK: begin
        c.cond   = CND_ROOTS_EQ;
        c.target = ST_RESULT;
      end
      ST_LINK: begin
        c.we    = 1'b1;
        c.wa    = WA_RA;
        c.accum = 1'b1;
      end
      ST_RESULT: begin
        c.load_out = 1'b1;
        c.wait_c   = 1'b1;
        c.cond     = CND_OUT_FREE;
        c.target   = ST_WAIT;
      end
      default: begin
        c.cond   = CND_ALWAYS;
        c.target = ST_WAIT;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[src/kufef_edge_if.sv]
// Interface: edge input channel (weight and two endpoint nodes).
`default_nettype none

interface kufef_edge_if;
  import kufef_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [WEIGHT_W-1:0]     edge_weight;
  logic [NODE_FIELD_W-1:0] node_a;
  logic [NODE_FIELD_W-1:0] node_b;

  modport source (output valid, output edge_weight, output node_a, output node_b,
                  input ready);
  modport sink (input valid, input edge_weight, input node_a, input node_b,
                output ready);
endinterface

`default_nettype wire

[src/kufef_result_if.sv]
// Interface: result channel (accept flag, running tree weight, saturation flag).
`default_nettype none

interface kufef_result_if;
  import kufef_pkg::*;

  logic               valid;
  logic               ready;
  logic               edge_accepted;
  logic [TOTAL_W-1:0] tree_weight;
  logic               weight_saturated;

  modport source (output valid, output edge_accepted, output tree_weight,
                  output weight_saturated, input ready);
  modport sink (input valid, input edge_accepted, input tree_weight,
                input weight_saturated, output ready);
endinterface

`default_nettype wire

[src/kruskal_union_find_edge_filter_top.sv]
// Top level: parent-table memory, find/compress datapath and result register.
// Per edge, the find of each endpoint walks its parent chain to the root and then compresses the
// path; each hop costs one walk read and one compression read/write pair in the parent memory
// (one read, one write a cycle). A joined edge adds one link write.
// Throughput: one edge at a time, next accept possible in the cycle after the result loads; a waiting
// result does not block the next accept, only the next result load. Reset: synchronous; then
// a clearing pass writes each of the NODE_COUNT (1024) parent entries with its own index,
// with edges.ready low; total and flag return to zero.
`default_nettype none

module kruskal_union_find_edge_filter_top (
  input  logic          clk,
  input  logic          rst,
  kufef_edge_if.sink    edges,
  kufef_result_if.source results
);
  import kufef_pkg::*;

  ctl_t   ctl;
  flags_t flags;

  logic [NODE_FIELD_W-1:0] na;
  logic [NODE_FIELD_W-1:0] nb;
  logic [WEIGHT_W-1:0]     wt;
  node_t                   cur;
  node_t                   root;
  node_t                   ra;
  node_t                   rdata;
  node_t                   cnt;
  node_t                   raddr;
  node_t                   waddr;
  node_t                   wdata;
  logic [TOTAL_W-1:0]      total;
  logic                    sat;
  logic                    acc;
  logic [TOTAL_W:0]        sum;

  logic                    out_valid;
  logic                    out_acc;
  logic [TOTAL_W-1:0]      out_total;
  logic                    out_sat;

  node_t parent_mem [NODE_COUNT];

  kufef_useq u_useq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl)
  );

  assign edges.ready = ctl.in_ready;

  assign flags.in_fire     = edges.valid && ctl.in_ready;
  assign flags.out_free    = !out_valid || results.ready;
  assign flags.clr_done    = (cnt == node_t'(NODE_COUNT - 1));
  assign flags.out_range   = (32'(na) >= NODE_COUNT) || (32'(nb) >= NODE_COUNT);
  assign flags.par_ne      = (rdata != root);
  assign flags.cur_is_root = (cur == root);
  assign flags.roots_eq    = (ra == root);

  always_comb begin
    unique case (ctl.rd)
      RD_ROOT:  raddr = root;
      RD_RDATA: raddr = rdata;
      RD_CUR:   raddr = cur;
      default:  raddr = root;
    endcase

    unique case (ctl.wa)
      WA_CUR:  waddr = cur;
      WA_RA:   waddr = ra;
      WA_CNT:  waddr = cnt;
      default: waddr = cur;
    endcase

    wdata = (ctl.wa == WA_CNT) ? cnt : root;
  end

  // Parent table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      parent_mem[waddr] <= wdata;
    end
    rdata <= parent_mem[raddr];
  end

  assign sum = {1'b0, total} + (TOTAL_W + 1)'(wt);

  // Payload registers
  always_ff @(posedge clk) begin
    if (flags.in_fire) begin
      na <= edges.node_a;
      nb <= edges.node_b;
      wt <= edges.edge_weight;
    end

    unique case (ctl.cur_ld)
      LD_NODE_A: cur <= node_t'(na);
      LD_NODE_B: cur <= node_t'(nb);
      LD_RDATA:  cur <= rdata;
      default:   cur <= cur;
    endcase

    unique case (ctl.root_ld)
      LD_NODE_A: root <= node_t'(na);
      LD_NODE_B: root <= node_t'(nb);
      LD_RDATA:  root <= rdata;
      default:   root <= root;
    endcase

    if (ctl.ra_ld) begin
      ra <= root;
    end

    if (ctl.clr_acc) begin
      acc <= 1'b0;
    end else if (ctl.accum) begin
      acc <= 1'b1;
    end

    if (ctl.load_out && flags.out_free) begin
      out_acc   <= acc;
      out_total <= total;
      out_sat   <= sat;
    end
  end

  // Control state: clear counter, running total, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      total     <= '0;
      sat       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.clr_inc) begin
        cnt <= cnt + 1'b1;
      end

      if (ctl.accum) begin
        if (sum[TOTAL_W]) begin
          total <= TOTAL_MAX;
          sat   <= 1'b1;
        end else begin
          total <= sum[TOTAL_W-1:0];
        end
      end

      if (ctl.load_out && flags.out_free) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign results.valid            = out_valid;
  assign results.edge_accepted    = out_acc;
  assign results.tree_weight      = out_total;
  assign results.weight_saturated = out_sat;

endmodule

`default_nettype wire

[src/kufef_useq.sv]
// Microsequencer: step counter, control store and conditional jump logic.
`default_nettype none

module kufef_useq (
  input  logic              clk,
  input  logic              rst,
  input  kufef_pkg::flags_t flags,
  output kufef_pkg::ctl_t   ctl
);
  import kufef_pkg::*;

  upc_t upc;
  upc_t upc_next;
  logic cond_true;

  assign ctl = ucode(upc);

  always_comb begin
    unique case (ctl.cond)
      CND_NEVER:       cond_true = 1'b0;
      CND_ALWAYS:      cond_true = 1'b1;
      CND_IN_FIRE:     cond_true = flags.in_fire;
      CND_OUT_FREE:    cond_true = flags.out_free;
      CND_CLR_DONE:    cond_true = flags.clr_done;
      CND_OUT_RANGE:   cond_true = flags.out_range;
      CND_PAR_NE:      cond_true = flags.par_ne;
      CND_CUR_IS_ROOT: cond_true = flags.cur_is_root;
      CND_ROOTS_EQ:    cond_true = flags.roots_eq;
      default:         cond_true = 1'b0;
    endcase

    if (cond_true) begin
      upc_next = upc_t'(ctl.target);
    end else if (ctl.wait_c) begin
      upc_next = upc;
    end else begin
      upc_next = upc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= upc_t'(ST_CLEAR);
    end else begin
      upc <= upc_next;
    end
  end

endmodule

`default_nettype wire

[src/kufef_chk.sv]
// Checker: port-level properties of the edge filter results, bound to the top level.
`default_nettype none

module kufef_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        edge_accepted,
  input logic [kufef_pkg::TOTAL_W-1:0] tree_weight,
  input logic                        weight_saturated
);
  import kufef_pkg::*;

  logic [TOTAL_W-1:0] prev_total;
  logic               sat_seen;

  // Totals reported by the previous result transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_total <= '0;
      sat_seen   <= 1'b0;
    end else if (out_valid && out_ready) begin
      prev_total <= tree_weight;
      sat_seen   <= sat_seen || weight_saturated;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tree_weight)
      && $stable(edge_accepted) && $stable(weight_saturated))
    else $error("result changed while stalled");

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && weight_saturated |-> tree_weight == TOTAL_MAX)
    else $error("saturated flag without maximum total");

  a_sat_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && sat_seen |-> weight_saturated)
    else $error("saturated flag dropped");

  a_reject_keeps: assert property (@(posedge clk) disable iff (rst)
    out_valid && !edge_accepted |-> tree_weight == prev_total)
    else $error("rejected edge changed the total");

  a_accept_grows: assert property (@(posedge clk) disable iff (rst)
    out_valid && edge_accepted |-> tree_weight >= prev_total)
    else $error("accepted edge lowered the total");

endmodule

bind kruskal_union_find_edge_filter_top kufef_chk u_chk (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (results.valid),
  .out_ready        (results.ready),
  .edge_accepted    (results.edge_accepted),
  .tree_weight      (results.tree_weight),
  .weight_saturated (results.weight_saturated)
);

`default_nettype wire

[sim/tb_top.sv]
// Testbench: Kruskal union-find edge filter, self-checking against a parent-table predictor.
`timescale 1ns / 100ps

module tb_top;
  import kufef_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int TAIL_CYCLES = 64;

  typedef struct packed {
    logic               joined;
    logic [TOTAL_W-1:0] total;
    logic               capped;
  } tree_result_t;

  logic clk;
  logic rst;

  kufef_edge_if   edges_ch ();
  kufef_result_if results_ch ();

  kruskal_union_find_edge_filter_top dut (
    .clk     (clk),
    .rst     (rst),
    .edges   (edges_ch),
    .results (results_ch)
  );

  // predictor state
  node_t              parent_of [NODE_COUNT];
  logic [TOTAL_W-1:0] tree_total;
  logic               total_capped;
  tree_result_t       tree_results_due [$];

  int  fail_count;
  int  edges_sent;
  int  results_seen;
  int  joins_seen;
  int  deepest_walk;
  int  cycle_count;
  bit  quiet_tx;
  bit  quiet_rx;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             tree_results_due.size());
    $display("kruskal_union_find_edge_filter_top regression: fail");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Root lookup with full path compression.
  function automatic node_t find_root(input node_t start);
    node_t top;
    node_t walk;
    node_t up;
    int    hops;
    top  = start;
    hops = 0;
    while (parent_of[top] != top && hops < NODE_COUNT) begin
      top = parent_of[top];
      hops++;
    end
    if (hops > deepest_walk) deepest_walk = hops;
    walk = start;
    hops = 0;
    while (walk != top && hops < NODE_COUNT) begin
      up              = parent_of[walk];
      parent_of[walk] = top;
      walk            = up;
      hops++;
    end
    return top;
  endfunction

  function automatic tree_result_t predict_edge(input logic [WEIGHT_W-1:0] w,
                                                input logic [NODE_FIELD_W-1:0] a,
                                                input logic [NODE_FIELD_W-1:0] b);
    tree_result_t res;
    node_t        root_a;
    node_t        root_b;
    res.joined = 1'b0;
    if (int'(a) < NODE_COUNT && int'(b) < NODE_COUNT) begin
      root_a = find_root(node_t'(a));
      root_b = find_root(node_t'(b));
      if (root_a != root_b) begin
        parent_of[root_a] = root_b;
        res.joined        = 1'b1;
        if (tree_total > TOTAL_MAX - {{(TOTAL_W-WEIGHT_W){1'b0}}, w}) begin
          tree_total   = TOTAL_MAX;
          total_capped = 1'b1;
        end else begin
          tree_total = tree_total + {{(TOTAL_W-WEIGHT_W){1'b0}}, w};
        end
      end
    end
    res.total  = tree_total;
    res.capped = total_capped;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [TOTAL_W-1:0] got,
                                 input logic [TOTAL_W-1:0] want);
    $display("%0t ns: result %0d %s mismatch: got %0d, want %0d", $time, results_seen,
             what, got, want);
    fail_count++;
  endtask

  task automatic send_edge(input logic [WEIGHT_W-1:0] w,
                           input logic [NODE_FIELD_W-1:0] a,
                           input logic [NODE_FIELD_W-1:0] b);
    int idle;
    idle = pick_gap(quiet_tx);
    @(negedge clk);
    if (idle != 0) begin
      edges_ch.valid = 1'b0;
      repeat (idle) @(negedge clk);
    end
    edges_ch.valid       = 1'b1;
    edges_ch.edge_weight = w;
    edges_ch.node_a      = a;
    edges_ch.node_b      = b;
    @(posedge clk);
    while (!edges_ch.ready) @(posedge clk);
    // transaction taken at this edge
    tree_results_due.push_back(predict_edge(w, a, b));
    if (tree_results_due[$].joined) joins_seen++;
    edges_sent++;
  endtask

  task automatic drop_valid();
    @(negedge clk);
    edges_ch.valid = 1'b0;
  endtask

  task automatic wait_for_results();
    while (tree_results_due.size() != 0) @(posedge clk);
  endtask

  // result side
  task automatic check_result();
    tree_result_t want;
    if (tree_results_due.size() == 0) begin
      $display("%0t ns: result with no edge waiting for it", $time);
      fail_count++;
    end else begin
      want = tree_results_due.pop_front();
      if (results_ch.edge_accepted !== want.joined)
        report_mismatch("edge_accepted", results_ch.edge_accepted, want.joined);
      if (results_ch.tree_weight !== want.total)
        report_mismatch("tree_weight", results_ch.tree_weight, want.total);
      if (results_ch.weight_saturated !== want.capped)
        report_mismatch("weight_saturated", results_ch.weight_saturated, want.capped);
    end
    results_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst && results_ch.valid && results_ch.ready) check_result();
  end

  initial begin
    int stall;
    results_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = pick_gap(quiet_rx);
      if (stall != 0) begin
        results_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      results_ch.ready = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  // Corner nodes and weights, duplicate link, self loop.
  task automatic test_reset_extremes();
    send_edge(32'h0000_0000, 10'd0, 10'd1023);
    send_edge(32'hFFFF_FFFF, 10'd1023, 10'd0);
    send_edge(32'hFFFF_FFFF, 10'd5, 10'd5);
    send_edge(32'hFFFF_FFFF, 10'd1, 10'd2);
    send_edge(32'h8000_0000, 10'd682, 10'd341);
    send_edge(32'h0000_0001, 10'd1022, 10'd1);
  endtask

  // Build a linear chain, then walk it end to end so every node gets rewritten.
  task automatic test_chain_compression();
    for (int k = 0; k < 11; k++)
      send_edge(32'(k * 3 + 7), 10'(200 + k), 10'(201 + k));
    send_edge(32'd100, 10'd200, 10'd211);
    send_edge(32'd101, 10'd200, 10'd300);
    send_edge(32'd102, 10'd300, 10'd205);
    send_edge(32'd103, 10'd0, 10'd210);
    send_edge(32'd104, 10'd1023, 10'd1023);
  endtask

  task automatic test_clustered_edges(input int count);
    int                      span;
    int                      origin;
    int                      step;
    bit                      chain_mode;
    logic [NODE_FIELD_W-1:0] a;
    logic [NODE_FIELD_W-1:0] b;
    logic [WEIGHT_W-1:0]     w;
    while (count > 0) begin
      chain_mode = 1'b0;
      case ($urandom_range(0, 6))
        0: span = 2;
        1: span = 4;
        2: span = 8;
        3: span = 16;
        4: span = 64;
        5: span = NODE_COUNT;
        default: begin
          span       = 40;
          chain_mode = 1'b1;
        end
      endcase
      origin   = $urandom_range(0, NODE_COUNT - span);
      quiet_tx = ($urandom_range(0, 3) == 0);
      quiet_rx = ($urandom_range(0, 3) == 0);
      step     = 0;
      repeat ($urandom_range(5, 30)) begin
        if (count > 0) begin
          case ($urandom_range(0, 3))
            0: w = $urandom;
            1: w = $urandom_range(0, 255);
            2: w = 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: w = 32'h1 << $urandom_range(0, 31);
          endcase
          if (chain_mode && step < span - 1) begin
            a = 10'(origin + step);
            b = 10'(origin + step + 1);
            step++;
          end else begin
            a = 10'(origin + $urandom_range(0, span - 1));
            b = 10'(origin + $urandom_range(0, span - 1));
          end
          if ($urandom_range(0, 7) == 0) b = a;
          send_edge(w, a, b);
          count--;
        end
      end
    end
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;
  endtask

  // Sender holds off until the result queue is empty, then resumes.
  task automatic test_drain_pause();
    repeat (8) send_edge($urandom, 10'($urandom), 10'($urandom));
    drop_valid();
    wait_for_results();
    repeat (8) send_edge($urandom_range(0, 15), 10'($urandom), 10'($urandom));
  endtask

  initial begin
    rst                  = 1'b1;
    edges_ch.valid       = 1'b0;
    edges_ch.edge_weight = '0;
    edges_ch.node_a      = '0;
    edges_ch.node_b      = '0;
    fail_count           = 0;
    edges_sent           = 0;
    results_seen         = 0;
    joins_seen           = 0;
    deepest_walk         = 0;
    cycle_count          = 0;
    quiet_tx             = 1'b0;
    quiet_rx             = 1'b0;
    for (int i = 0; i < NODE_COUNT; i++) parent_of[i] = node_t'(i);
    tree_total   = '0;
    total_capped = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_extremes();
    test_chain_compression();
    test_clustered_edges(200);
    test_drain_pause();
    test_clustered_edges(215);

    drop_valid();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d edges checked: %0d joined two sets, %0d rejected in one set or self loop",
             results_seen, joins_seen, edges_sent - joins_seen);
    $display("deepest parent walk %0d hops, final tree weight %0d, saturation flag %0b",
             deepest_walk, tree_total, total_capped);
    if (fail_count == 0) begin
      $display("kruskal_union_find_edge_filter_top regression: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("kruskal_union_find_edge_filter_top regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
src/kufef_pkg.sv
src/kufef_edge_if.sv
src/kufef_result_if.sv
src/kufef_useq.sv
src/kruskal_union_find_edge_filter_top.sv
src/kufef_chk.sv
sim/tb_top.sv
